[src/double_hash_table_engine_defines.svh]
// Assertion macros used by the double hash table engine back part.
`ifndef DOUBLE_HASH_TABLE_ENGINE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DHTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dhte assertion failed");

// Next-cycle implication, checked outside reset.
`define DHTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dhte assertion failed");

`endif

[src/dhte_pkg.sv]
// Types, constants and helpers of the double hash table engine.
`default_nettype none
package dhte_pkg;
  localparam int TABLE_DEPTH   = 1024;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int CAP_W         = 11;
  localparam int NB_W          = 4;
  localparam int KEY_W         = 64;
  localparam int VALUE_W       = 32;
  localparam int MAX_KEY_BYTES = 8;
  localparam int CFG_W         = 11;
  localparam logic [KEY_W-1:0] DJB_START = 64'd5381;

  localparam logic CFG_CAPACITY  = 1'b0;
  localparam logic CFG_KEY_BYTES = 1'b1;

  localparam logic KIND_INSERT = 1'b0;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_DIV, F_PUSH} front_state_e;
  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_CHECK} back_state_e;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic [NB_W-1:0]  key_bytes;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   mask;
    logic [VALUE_W-1:0] value;
    logic [CAP_W-1:0]   cap;
    logic [ADDR_W-1:0]  home;
    logic [ADDR_W-1:0]  step;
  } item_t;

  function automatic logic [KEY_W-1:0] key_mask(input logic [NB_W-1:0] nb);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < MAX_KEY_BYTES; b++) begin
      if (NB_W'(b) < nb) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction
endpackage
`default_nettype wire

[src/double_hash_table_engine.sv]
// Top level of the double hash table engine: configuration registers and wiring.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   in_kind_i, in_key_i, in_value_i
//  out      output     out_valid_o / out_stall_i out_status_o, out_value_out_o,
//                                                out_entry_count_o
//  cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// The front is busy with each transaction: it hashes one byte of the key a cycle, then takes
// one dividend bit a cycle for both remainders, then pushes into the queue once it is not full.
// The back pops an item when its output is free, then for each probe reads the slot memory
// in B_READ and compares in B_CHECK, and finally registers the result.
// After reset the valid store is cleared slot by slot; no input is taken then.
// A stalled output holds its result; the queue lets the front hash the next item.
`default_nettype none
module double_hash_table_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [dhte_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          in_kind_i,
  input  wire logic [dhte_pkg::KEY_W-1:0]    in_key_i,
  input  wire logic [dhte_pkg::VALUE_W-1:0]  in_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         out_status_o,
  output logic [dhte_pkg::VALUE_W-1:0]       out_value_out_o,
  output logic [dhte_pkg::CAP_W-1:0]         out_entry_count_o
);
  dhte_pkg::cfg_t  cfg_q;
  dhte_pkg::item_t f_item, q_item;
  logic push, full, pop, q_valid, clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity  <= dhte_pkg::CAP_W'(1021);
      cfg_q.key_bytes <= dhte_pkg::NB_W'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dhte_pkg::CFG_CAPACITY:  cfg_q.capacity  <= cfg_data_i[dhte_pkg::CAP_W-1:0];
        dhte_pkg::CFG_KEY_BYTES: cfg_q.key_bytes <= cfg_data_i[dhte_pkg::NB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dhte_front u_front (
    .clk_i, .rst_ni,
    .cfg_i      (cfg_q),
    .clearing_i (clearing),
    .in_valid_i, .in_stall_o, .in_kind_i, .in_key_i, .in_value_i,
    .push_o     (push),
    .item_o     (f_item),
    .full_i     (full)
  );

  dhte_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  dhte_back u_back (
    .clk_i, .rst_ni,
    .clearing_o (clearing),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .pop_o      (pop),
    .out_valid_o, .out_stall_i, .out_status_o, .out_value_out_o, .out_entry_count_o
  );
endmodule
`default_nettype wire

[src/dhte_front.sv]
// Front part: accepts a transaction, hashes the key and derives home slot and step.
`default_nettype none
module dhte_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dhte_pkg::cfg_t              cfg_i,
  input  wire logic                        clearing_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        in_kind_i,
  input  wire logic [dhte_pkg::KEY_W-1:0]  in_key_i,
  input  wire logic [dhte_pkg::VALUE_W-1:0] in_value_i,
  output logic                             push_o,
  output dhte_pkg::item_t                  item_o,
  input  wire logic                        full_i
);
  dhte_pkg::front_state_e state_q, state_d;
  logic [dhte_pkg::CAP_W-1:0] cap_eff;
  logic [dhte_pkg::NB_W-1:0]  nb_eff;
  logic accept;

  logic                          kind_q;
  logic [dhte_pkg::KEY_W-1:0]    key_q, mask_q, h_q;
  logic [dhte_pkg::VALUE_W-1:0]  value_q;
  logic [dhte_pkg::CAP_W-1:0]    cap_q, r1_q, r2_q;
  logic [dhte_pkg::NB_W-1:0]     nb_q;
  logic [2:0]                    byte_q;
  logic [5:0]                    bit_q;

  logic [7:0]                    cur_byte;
  logic [dhte_pkg::CAP_W:0]      r1_sh, r2_sh;
  logic                          qbit;
  logic [dhte_pkg::CAP_W-1:0]    r1_n, r2_n;
  logic                          hash_last, div_last;

  always_comb begin
    cap_eff = cfg_i.capacity;
    if (cap_eff == '0) cap_eff = dhte_pkg::CAP_W'(1);
    if (cap_eff > dhte_pkg::CAP_W'(dhte_pkg::TABLE_DEPTH))
      cap_eff = dhte_pkg::CAP_W'(dhte_pkg::TABLE_DEPTH);
    nb_eff = cfg_i.key_bytes;
    if (nb_eff == '0) nb_eff = dhte_pkg::NB_W'(1);
    if (nb_eff > dhte_pkg::NB_W'(dhte_pkg::MAX_KEY_BYTES))
      nb_eff = dhte_pkg::NB_W'(dhte_pkg::MAX_KEY_BYTES);
  end

  assign cur_byte  = key_q[{byte_q, 3'b000} +: 8];
  assign hash_last = ({1'b0, byte_q} == nb_q - dhte_pkg::NB_W'(1));
  assign div_last  = (bit_q == 6'd63);

  // Both remainders advance one dividend bit a cycle; the quotient bit of the
  // first division feeds the second as it appears, MSB first.
  always_comb begin
    r1_sh = {r1_q, h_q[dhte_pkg::KEY_W-1]};
    qbit  = (r1_sh >= {1'b0, cap_q});
    r1_n  = qbit ? dhte_pkg::CAP_W'(r1_sh - {1'b0, cap_q}) : r1_sh[dhte_pkg::CAP_W-1:0];
    r2_sh = {r2_q, qbit};
    r2_n  = (r2_sh >= {1'b0, cap_q}) ? dhte_pkg::CAP_W'(r2_sh - {1'b0, cap_q})
                                     : r2_sh[dhte_pkg::CAP_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dhte_pkg::F_IDLE: if (accept) state_d = dhte_pkg::F_HASH;
      dhte_pkg::F_HASH: if (hash_last) state_d = dhte_pkg::F_DIV;
      dhte_pkg::F_DIV:  if (div_last) state_d = dhte_pkg::F_PUSH;
      dhte_pkg::F_PUSH: if (!full_i) state_d = dhte_pkg::F_IDLE;
      default:          state_d = dhte_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != dhte_pkg::F_IDLE) || clearing_i;
    push_o     = (state_q == dhte_pkg::F_PUSH) && !full_i;
  end

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    item_o.kind  = kind_q;
    item_o.key   = key_q;
    item_o.mask  = mask_q;
    item_o.value = value_q;
    item_o.cap   = cap_q;
    item_o.home  = r1_q[dhte_pkg::ADDR_W-1:0];
    item_o.step  = (r2_q == '0) ? dhte_pkg::ADDR_W'(1) : r2_q[dhte_pkg::ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dhte_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      dhte_pkg::F_IDLE: begin
        if (accept) begin
          kind_q  <= in_kind_i;
          mask_q  <= dhte_pkg::key_mask(nb_eff);
          key_q   <= in_key_i & dhte_pkg::key_mask(nb_eff);
          value_q <= in_value_i;
          cap_q   <= cap_eff;
          nb_q    <= nb_eff;
          h_q     <= dhte_pkg::DJB_START;
          byte_q  <= '0;
          bit_q   <= '0;
          r1_q    <= '0;
          r2_q    <= '0;
        end
      end
      dhte_pkg::F_HASH: begin
        h_q    <= (h_q << 5) + h_q + {56'd0, cur_byte};
        byte_q <= byte_q + 3'd1;
      end
      dhte_pkg::F_DIV: begin
        r1_q  <= r1_n;
        r2_q  <= r2_n;
        h_q   <= h_q << 1;
        bit_q <= bit_q + 6'd1;
      end
      dhte_pkg::F_PUSH: begin
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

[src/dhte_queue.sv]
// Two-entry queue between the front and back parts.
`default_nettype none
module dhte_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire dhte_pkg::item_t item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output dhte_pkg::item_t      item_o
);
  dhte_pkg::item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end
endmodule
`default_nettype wire

[src/dhte_back.sv]
// Back part: walks the probe sequence in the slot memories and returns results.
`default_nettype none
`include "double_hash_table_engine_defines.svh"
module dhte_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  output logic                               clearing_o,
  input  wire logic                          q_valid_i,
  input  wire dhte_pkg::item_t               q_item_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         out_status_o,
  output logic [dhte_pkg::VALUE_W-1:0]       out_value_out_o,
  output logic [dhte_pkg::CAP_W-1:0]         out_entry_count_o
);
  localparam int AW = dhte_pkg::ADDR_W;
  localparam int CW = dhte_pkg::CAP_W;

  logic                         vld_mem [dhte_pkg::TABLE_DEPTH];
  logic [dhte_pkg::KEY_W-1:0]   key_mem [dhte_pkg::TABLE_DEPTH];
  logic [dhte_pkg::VALUE_W-1:0] val_mem [dhte_pkg::TABLE_DEPTH];

  dhte_pkg::back_state_e state_q, state_d;
  dhte_pkg::item_t       it_q;
  logic [AW-1:0]         idx_q, clr_q;
  logic [CW-1:0]         n_q, occ_q, limit;
  logic                  rd_vld_q;
  logic [dhte_pkg::KEY_W-1:0]   rd_key_q;
  logic [dhte_pkg::VALUE_W-1:0] rd_val_q;

  logic          out_valid_q;
  logic [2:0]    status_q;
  logic [dhte_pkg::VALUE_W-1:0] vout_q;

  logic          out_free, start, exhausted, hit, finish, wr_new, wr_upd;
  logic [CW:0]   idx_sum;
  logic [AW-1:0] idx_next;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign limit     = (it_q.kind == dhte_pkg::KIND_INSERT) ? it_q.cap : occ_q;
  assign exhausted = (n_q >= limit);
  assign hit       = ((rd_key_q & it_q.mask) == it_q.key);
  assign idx_sum   = {1'b0, CW'(idx_q)} + {1'b0, CW'(it_q.step)};
  assign idx_next  = (idx_sum >= {1'b0, it_q.cap}) ? AW'(idx_sum - {1'b0, it_q.cap})
                                                   : idx_sum[AW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dhte_pkg::B_CLEAR: if (clr_q == '1) state_d = dhte_pkg::B_IDLE;
      dhte_pkg::B_IDLE:  if (start) state_d = dhte_pkg::B_READ;
      dhte_pkg::B_READ:  state_d = exhausted ? dhte_pkg::B_IDLE : dhte_pkg::B_CHECK;
      dhte_pkg::B_CHECK: state_d = (!rd_vld_q || hit) ? dhte_pkg::B_IDLE : dhte_pkg::B_READ;
      default:           state_d = dhte_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    clearing_o = (state_q == dhte_pkg::B_CLEAR);
    start      = (state_q == dhte_pkg::B_IDLE) && q_valid_i && out_free;
    pop_o      = start;
    finish     = ((state_q == dhte_pkg::B_READ) && exhausted) ||
                 ((state_q == dhte_pkg::B_CHECK) && (!rd_vld_q || hit));
    wr_new     = (state_q == dhte_pkg::B_CHECK) && !rd_vld_q &&
                 (it_q.kind == dhte_pkg::KIND_INSERT);
    wr_upd     = (state_q == dhte_pkg::B_CHECK) && rd_vld_q && hit &&
                 (it_q.kind == dhte_pkg::KIND_INSERT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dhte_pkg::B_CLEAR;
      clr_q       <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == dhte_pkg::B_CLEAR) clr_q <= clr_q + AW'(1);
      if (wr_new) occ_q <= occ_q + CW'(1);
      if (finish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Result payload and probe datapath.
  always_ff @(posedge clk_i) begin
    if (start) begin
      it_q  <= q_item_i;
      idx_q <= q_item_i.home;
      n_q   <= '0;
    end
    if ((state_q == dhte_pkg::B_CHECK) && rd_vld_q && !hit) begin
      idx_q <= idx_next;
      n_q   <= n_q + CW'(1);
    end
    if (finish) begin
      vout_q <= '0;
      if (state_q == dhte_pkg::B_READ) begin
        status_q <= (it_q.kind == dhte_pkg::KIND_INSERT) ? 3'(dhte_pkg::ST_FULL)
                                                        : 3'(dhte_pkg::ST_NOT_FOUND);
      end else if (!rd_vld_q) begin
        status_q <= (it_q.kind == dhte_pkg::KIND_INSERT) ? 3'(dhte_pkg::ST_INSERTED)
                                                        : 3'(dhte_pkg::ST_NOT_FOUND);
      end else if (it_q.kind == dhte_pkg::KIND_INSERT) begin
        status_q <= 3'(dhte_pkg::ST_UPDATED);
      end else begin
        status_q <= 3'(dhte_pkg::ST_FOUND);
        vout_q   <= rd_val_q;
      end
    end
  end

  // Slot memories with registered reads.
  always_ff @(posedge clk_i) begin
    rd_vld_q <= vld_mem[idx_q];
    rd_key_q <= key_mem[idx_q];
    rd_val_q <= val_mem[idx_q];
    if (state_q == dhte_pkg::B_CLEAR) vld_mem[clr_q] <= 1'b0;
    else if (wr_new) vld_mem[idx_q] <= 1'b1;
    if (wr_new) key_mem[idx_q] <= it_q.key;
    if (wr_new || wr_upd) val_mem[idx_q] <= it_q.value;
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = status_q;
  assign out_value_out_o   = vout_q;
  assign out_entry_count_o = occ_q;

  `DHTE_ASSERT_NOW(a_finish_free, clk_i, rst_ni, finish, !out_valid_q)
  `DHTE_ASSERT_NOW(a_no_pop_clear, clk_i, rst_ni, clearing_o, !pop_o)
  `DHTE_ASSERT_NOW(a_idx_in_range, clk_i, rst_ni, state_q == dhte_pkg::B_READ,
                   CW'(idx_q) < it_q.cap)
  `DHTE_ASSERT_NEXT(a_occ_inc, clk_i, rst_ni, wr_new, occ_q == $past(occ_q) + CW'(1))
endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the double hash table engine with a scoreboard class.
`default_nettype none
module testbench;

  class hash_table_scoreboard;
    typedef struct {
      dhte_pkg::status_e                status;
      logic [dhte_pkg::VALUE_W-1:0]     value;
      logic [dhte_pkg::CAP_W-1:0]       count;
    } reply_t;

    bit                           slot_valid[dhte_pkg::TABLE_DEPTH];
    logic [dhte_pkg::KEY_W-1:0]   slot_key[dhte_pkg::TABLE_DEPTH];
    logic [dhte_pkg::VALUE_W-1:0] slot_value[dhte_pkg::TABLE_DEPTH];
    int unsigned                  occupied;
    logic [dhte_pkg::CAP_W-1:0]   capacity_reg;
    logic [dhte_pkg::NB_W-1:0]    key_bytes_reg;
    reply_t                       pending_replies[$];
    int                           errors;
    int                           status_seen[5];
    int                           replies_checked;

    function new();
      occupied = 0;
      capacity_reg = 11'd1021;
      key_bytes_reg = 4'd4;
      errors = 0;
      replies_checked = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_register(logic idx, logic [dhte_pkg::CFG_W-1:0] data);
      if (idx == dhte_pkg::CFG_CAPACITY) capacity_reg = data;
      else key_bytes_reg = data[dhte_pkg::NB_W-1:0];
    endfunction

    // Works out the reply of one accepted request and updates the table copy.
    function void note_request(logic kind, logic [dhte_pkg::KEY_W-1:0] key_in,
                               logic [dhte_pkg::VALUE_W-1:0] value_in);
      int unsigned                cap;
      int unsigned                nb;
      logic [dhte_pkg::KEY_W-1:0] mask;
      logic [dhte_pkg::KEY_W-1:0] key;
      logic [dhte_pkg::KEY_W-1:0] h;
      int unsigned                idx;
      int unsigned                step;
      reply_t                     r;
      cap = (capacity_reg == 0) ? 1 : capacity_reg;
      if (cap > dhte_pkg::TABLE_DEPTH) cap = dhte_pkg::TABLE_DEPTH;
      nb = (key_bytes_reg == 0) ? 1 : key_bytes_reg;
      if (nb > dhte_pkg::MAX_KEY_BYTES) nb = dhte_pkg::MAX_KEY_BYTES;
      mask = (nb == 8) ? '1 : ((64'd1 << (8 * nb)) - 64'd1);
      key = key_in & mask;
      h = dhte_pkg::DJB_START;
      for (int b = 0; b < nb; b++) h = h * 64'd33 + 64'(key[b*8 +: 8]);
      idx = int'(h % 64'(cap));
      step = int'((h / 64'(cap)) % 64'(cap));
      if (step == 0) step = 1;
      r.value = '0;
      if (kind == dhte_pkg::KIND_INSERT) begin
        r.status = dhte_pkg::ST_FULL;
        for (int n = 0; n < cap; n++) begin
          if (!slot_valid[idx]) begin
            slot_valid[idx] = 1'b1;
            slot_key[idx] = key;
            slot_value[idx] = value_in;
            occupied++;
            r.status = dhte_pkg::ST_INSERTED;
            break;
          end
          if ((slot_key[idx] & mask) == key) begin
            slot_value[idx] = value_in;
            r.status = dhte_pkg::ST_UPDATED;
            break;
          end
          idx = (idx + step) % cap;
        end
      end else begin
        r.status = dhte_pkg::ST_NOT_FOUND;
        for (int n = 0; n < occupied; n++) begin
          if (!slot_valid[idx]) break;
          if ((slot_key[idx] & mask) == key) begin
            r.status = dhte_pkg::ST_FOUND;
            r.value = slot_value[idx];
            break;
          end
          idx = (idx + step) % cap;
        end
      end
      r.count = occupied[dhte_pkg::CAP_W-1:0];
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [2:0] status, logic [dhte_pkg::VALUE_W-1:0] value,
                              logic [dhte_pkg::CAP_W-1:0] count);
      reply_t r;
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding: status %0d", status);
        errors++;
        return;
      end
      r = pending_replies.pop_front();
      replies_checked++;
      if (status < 5) status_seen[status]++;
      if (status !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, status);
        errors++;
      end
      if (value !== r.value) begin
        $error("value_out: expected %h, got %h", r.value, value);
        errors++;
      end
      if (count !== r.count) begin
        $error("entry_count: expected %0d, got %0d", r.count, count);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic                         cfg_idx_i;
  logic [dhte_pkg::CFG_W-1:0]   cfg_data_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         in_kind_i;
  logic [dhte_pkg::KEY_W-1:0]   in_key_i;
  logic [dhte_pkg::VALUE_W-1:0] in_value_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [2:0]                   out_status_o;
  logic [dhte_pkg::VALUE_W-1:0] out_value_out_o;
  logic [dhte_pkg::CAP_W-1:0]   out_entry_count_o;

  hash_table_scoreboard sb;
  int burst_left;
  int stall_left;
  int stall_mode;
  int cur_key_bytes;

  double_hash_table_engine dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_kind_i, .in_key_i, .in_value_i,
    .out_valid_o, .out_stall_i, .out_status_o, .out_value_out_o, .out_entry_count_o
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #150000000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_reply(out_status_o, out_value_out_o, out_entry_count_o);
  end

  // The receiver switches between free running, light, heavy and long stalls.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall_i <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_stall_i <= ((stall_left % 60) < 35);
      end
    endcase
  end

  // Called at a falling edge; returns at a falling edge after the transaction.
  task automatic send_item(logic kind, logic [dhte_pkg::KEY_W-1:0] key,
                           logic [dhte_pkg::VALUE_W-1:0] value);
    int gap;
    in_valid_i <= 1'b1;
    in_kind_i  <= kind;
    in_key_i   <= key;
    in_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(kind, key, value);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_register(logic idx, int unsigned data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data[dhte_pkg::CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_register(idx, data[dhte_pkg::CFG_W-1:0]);
    if (idx == dhte_pkg::CFG_KEY_BYTES) cur_key_bytes = data[dhte_pkg::NB_W-1:0];
    @(negedge clk_i);
  endtask

  // Most keys come from a small pool of low bytes with random ignored bytes above.
  function automatic logic [dhte_pkg::KEY_W-1:0] random_key();
    logic [dhte_pkg::KEY_W-1:0] k;
    int                         nb;
    k = {$urandom, $urandom};
    nb = (cur_key_bytes == 0) ? 1 : (cur_key_bytes > 8 ? 8 : cur_key_bytes);
    if ($urandom_range(0, 9) < 8) begin
      if (nb < 8) k = (k & ~((64'd1 << (8 * nb)) - 64'd1)) | 64'($urandom_range(0, 40));
      else k = 64'($urandom_range(0, 40)) | ($urandom_range(0, 1) ? 64'hFF00_0000_0000_0000 : 0);
    end
    return k;
  endfunction

  task automatic run_phase(int unsigned cap, int unsigned kb, int items);
    logic [dhte_pkg::VALUE_W-1:0] v;
    drain();
    write_register(dhte_pkg::CFG_CAPACITY, cap);
    write_register(dhte_pkg::CFG_KEY_BYTES, kb);
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(0, 9))
        0: v = '0;
        1: v = '1;
        default: v = $urandom;
      endcase
      send_item(1'($urandom_range(0, 1)), random_key(), v);
    end
  endtask

  initial begin
    sb = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = dhte_pkg::CFG_CAPACITY;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_kind_i   = dhte_pkg::KIND_INSERT;
    in_key_i    = '0;
    in_value_i  = '0;
    out_stall_i = 1'b0;
    burst_left  = 0;
    stall_left  = 0;
    cur_key_bytes = 4;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed requests under the reset configuration.
    send_item(dhte_pkg::KIND_INSERT, '0, '0);
    send_item(dhte_pkg::KIND_INSERT, '1, '1);
    send_item(~dhte_pkg::KIND_INSERT, '0, '1);
    send_item(~dhte_pkg::KIND_INSERT, 64'hABCD_0000_FFFF_FFFF, '0);
    send_item(dhte_pkg::KIND_INSERT, 64'h1234_5678_FFFF_FFFF, 32'h5);
    send_item(~dhte_pkg::KIND_INSERT, '1, '0);
    send_item(~dhte_pkg::KIND_INSERT, 64'h0000_0000_0000_1234, '0);
    send_item(dhte_pkg::KIND_INSERT, 64'h5555_5555_AAAA_AAAA, 32'hAAAA_5555);
    send_item(~dhte_pkg::KIND_INSERT, 64'h0000_0000_AAAA_AAAA, '0);
    // Single slot: the second distinct key finds the table full.
    run_phase(1, 1, 0);
    send_item(dhte_pkg::KIND_INSERT, 64'h11, 32'h1);
    send_item(dhte_pkg::KIND_INSERT, 64'h22, 32'h2);
    send_item(dhte_pkg::KIND_INSERT, 64'h11, 32'h3);
    send_item(~dhte_pkg::KIND_INSERT, 64'h11, '0);
    send_item(~dhte_pkg::KIND_INSERT, 64'h22, '0);
    // Zero capacity and zero key length fall back to one.
    run_phase(0, 0, 30);
    run_phase(2, 8, 60);
    run_phase(7, 3, 150);
    run_phase(13, 2, 200);
    run_phase(31, 8, 230);
    run_phase(61, 1, 230);
    run_phase(2047, 15, 60);
    run_phase(1024, 8, 60);
    run_phase(97, 5, 200);
    run_phase(4, 4, 100);
    run_phase(11, 7, 110);
    drain();
    repeat (200) @(negedge clk_i);

    $display("Checked %0d replies over thirteen register settings, including the extremes.",
             sb.replies_checked);
    $display("Replies seen: %0d inserted, %0d updated, %0d found, %0d missing, %0d full.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4]);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

[double_hash_table_engine.f]
+incdir+src
src/dhte_pkg.sv
src/dhte_front.sv
src/dhte_queue.sv
src/dhte_back.sv
src/double_hash_table_engine.sv
bench/testbench.sv
